/* rtl/ut2cal_pkg.sv */
// Shared types, constants and the month-length table for the Unix time to calendar converter.
`default_nettype none
package ut2cal_pkg;

  // reciprocals: x/15 is (x*M)>>35, x/3 is (x*M)>>33, x/7 is (x*M)>>20 for x below 2^17
  localparam logic [31:0] MAGIC_DIV15 = 32'h8888_8889;
  localparam logic [31:0] MAGIC_DIV3  = 32'hAAAA_AAAB;
  localparam logic [31:0] MAGIC_DIV7  = 32'd149797;

  localparam logic [15:0] ANCHOR_DAYS_2000 = 16'd10957;
  localparam logic [15:0] ANCHOR_DAYS_2019 = 16'd17897;

  localparam logic [11:0] YEAR_1970 = 12'd1970;
  localparam logic [11:0] YEAR_2000 = 12'd2000;
  localparam logic [11:0] YEAR_2019 = 12'd2019;

  localparam logic [8:0] DAYS_PER_YEAR = 9'd365;
  localparam logic [8:0] DAYS_PER_LEAP = 9'd366;

  localparam logic [3:0] MONTH_FEB  = 4'd1;
  localparam logic [3:0] MONTH_LAST = 4'd11;

  typedef enum logic [1:0] {
    SPLIT_SEC,
    SPLIT_MIN,
    SPLIT_HOUR,
    SPLIT_WDAY
  } div_sel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_SEC,
    S_SPLIT_SEC,
    S_MUL_MIN,
    S_SPLIT_MIN,
    S_MUL_HOUR,
    S_SPLIT_HOUR,
    S_MUL_WDAY,
    S_SPLIT_WDAY,
    S_ANCHOR,
    S_YEAR,
    S_MONTH
  } state_t;

  typedef struct packed {
    logic     load;
    logic     mul;
    logic     split;
    div_sel_t sel;
    logic     anchor;
    logic     year_step;
    logic     month_step;
    logic     capture;
  } dp_cmd_t;

  typedef struct packed {
    logic year_done;
    logic month_done;
  } dp_status_t;

  function automatic logic [4:0] month_len(input logic [3:0] idx);
    logic [4:0] len;
    case (idx)
      4'd1:    len = 5'd28;
      4'd3:    len = 5'd30;
      4'd5:    len = 5'd30;
      4'd8:    len = 5'd30;
      4'd10:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage
`default_nettype wire

/* rtl/ut2cal_dp.sv */
// Datapath: shared reciprocal multiplier for the time splits and weekday, year and month stepping.
`default_nettype none
module ut2cal_dp (
  input  wire logic                   clk,
  input  wire ut2cal_pkg::dp_cmd_t    cmd,
  output ut2cal_pkg::dp_status_t      status,
  input  wire logic [31:0]            unix_seconds,
  output logic [5:0]                  sec_of_minute,
  output logic [5:0]                  min_of_hour,
  output logic [4:0]                  hour_of_day,
  output logic [2:0]                  day_of_week,
  output logic [4:0]                  day_of_month,
  output logic [3:0]                  month_of_year,
  output logic [11:0]                 calendar_year
);
  import ut2cal_pkg::*;

  logic [31:0] acc;
  logic [31:0] quo;
  logic [5:0]  secs;
  logic [5:0]  mins;
  logic [4:0]  hour;
  logic [2:0]  wday;
  logic [15:0] dcnt;
  logic [11:0] year;
  logic [1:0]  m4;
  logic [6:0]  m100;
  logic [8:0]  m400;
  logic [3:0]  mon_idx;

  logic [31:0] acc_p3;
  logic [31:0] mul_a;
  logic [31:0] magic;
  logic [63:0] prod;
  logic [31:0] quo_next;
  logic [31:0] part;
  logic [31:0] rem_full;
  logic        leap;
  logic [8:0]  ylen;
  logic [4:0]  mlen;

  assign acc_p3 = acc + 32'd3;

  // x/60 = (x>>2)/15, x/24 = (x>>3)/3
  always_comb begin
    case (cmd.sel)
      SPLIT_SEC, SPLIT_MIN: begin
        mul_a = {2'd0, acc[31:2]};
        magic = MAGIC_DIV15;
      end
      SPLIT_HOUR: begin
        mul_a = {3'd0, acc[31:3]};
        magic = MAGIC_DIV3;
      end
      default: begin
        mul_a = acc_p3;
        magic = MAGIC_DIV7;
      end
    endcase
  end

  assign prod = 64'(mul_a) * 64'(magic);

  always_comb begin
    case (cmd.sel)
      SPLIT_SEC, SPLIT_MIN: quo_next = {3'd0, prod[63:35]};
      SPLIT_HOUR:           quo_next = {1'd0, prod[63:33]};
      default:              quo_next = prod[51:20];
    endcase
  end

  // remainder from the registered quotient: times 60, 24 or 7 by shifts
  always_comb begin
    case (cmd.sel)
      SPLIT_SEC, SPLIT_MIN: begin
        part     = {quo[25:0], 6'd0} - {quo[29:0], 2'd0};
        rem_full = acc - part;
      end
      SPLIT_HOUR: begin
        part     = {quo[27:0], 4'd0} + {quo[28:0], 3'd0};
        rem_full = acc - part;
      end
      default: begin
        part     = {quo[28:0], 3'd0} - quo;
        rem_full = acc_p3 - part;
      end
    endcase
  end

  assign leap = ((m4 == 2'd0) && (m100 != 7'd0)) || (m400 == 9'd0);
  assign ylen = leap ? DAYS_PER_LEAP : DAYS_PER_YEAR;
  assign mlen = month_len(mon_idx) + {4'd0, (leap && (mon_idx == MONTH_FEB))};

  assign status.year_done  = dcnt < {7'd0, ylen};
  assign status.month_done = (dcnt < {11'd0, mlen}) || (mon_idx == MONTH_LAST);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      acc <= unix_seconds;
    end
    if (cmd.mul) begin
      quo <= quo_next;
    end
    if (cmd.split) begin
      case (cmd.sel)
        SPLIT_SEC: begin
          secs <= rem_full[5:0];
          acc  <= quo;
        end
        SPLIT_MIN: begin
          mins <= rem_full[5:0];
          acc  <= quo;
        end
        SPLIT_HOUR: begin
          hour <= rem_full[4:0];
          acc  <= quo;
          dcnt <= quo[15:0];
        end
        default: begin
          wday <= rem_full[2:0];
        end
      endcase
    end
    if (cmd.anchor) begin
      mon_idx <= 4'd0;
      if (dcnt >= ANCHOR_DAYS_2019) begin
        year <= YEAR_2019;
        dcnt <= dcnt - ANCHOR_DAYS_2019;
        m4   <= 2'd3;
        m100 <= 7'd19;
        m400 <= 9'd19;
      end else if (dcnt >= ANCHOR_DAYS_2000) begin
        year <= YEAR_2000;
        dcnt <= dcnt - ANCHOR_DAYS_2000;
        m4   <= 2'd0;
        m100 <= 7'd0;
        m400 <= 9'd0;
      end else begin
        year <= YEAR_1970;
        m4   <= 2'd2;
        m100 <= 7'd70;
        m400 <= 9'd370;
      end
    end
    if (cmd.year_step) begin
      dcnt <= dcnt - {7'd0, ylen};
      year <= year + 12'd1;
      m4   <= m4 + 2'd1;
      m100 <= (m100 == 7'd99) ? 7'd0 : m100 + 7'd1;
      m400 <= (m400 == 9'd399) ? 9'd0 : m400 + 9'd1;
    end
    if (cmd.month_step) begin
      dcnt    <= dcnt - {11'd0, mlen};
      mon_idx <= mon_idx + 4'd1;
    end
    if (cmd.capture) begin
      sec_of_minute <= secs;
      min_of_hour   <= mins;
      hour_of_day   <= hour;
      day_of_week   <= wday;
      day_of_month  <= dcnt[4:0] + 5'd1;
      month_of_year <= mon_idx + 4'd1;
      calendar_year <= year;
    end
  end

endmodule
`default_nettype wire

/* rtl/ut2cal_ctrl.sv */
// Controller: sequences the multiply and split steps, year and month steps and owns both handshakes.
`default_nettype none
module ut2cal_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output ut2cal_pkg::dp_cmd_t         cmd,
  input  wire ut2cal_pkg::dp_status_t status
);
  import ut2cal_pkg::*;

  state_t state, state_next;

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.capture) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.sel    = SPLIT_SEC;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_MUL_SEC;
        end
      end
      S_MUL_SEC: begin
        cmd.mul    = 1'b1;
        cmd.sel    = SPLIT_SEC;
        state_next = S_SPLIT_SEC;
      end
      S_SPLIT_SEC: begin
        cmd.split  = 1'b1;
        cmd.sel    = SPLIT_SEC;
        state_next = S_MUL_MIN;
      end
      S_MUL_MIN: begin
        cmd.mul    = 1'b1;
        cmd.sel    = SPLIT_MIN;
        state_next = S_SPLIT_MIN;
      end
      S_SPLIT_MIN: begin
        cmd.split  = 1'b1;
        cmd.sel    = SPLIT_MIN;
        state_next = S_MUL_HOUR;
      end
      S_MUL_HOUR: begin
        cmd.mul    = 1'b1;
        cmd.sel    = SPLIT_HOUR;
        state_next = S_SPLIT_HOUR;
      end
      S_SPLIT_HOUR: begin
        cmd.split  = 1'b1;
        cmd.sel    = SPLIT_HOUR;
        state_next = S_MUL_WDAY;
      end
      S_MUL_WDAY: begin
        cmd.mul    = 1'b1;
        cmd.sel    = SPLIT_WDAY;
        state_next = S_SPLIT_WDAY;
      end
      S_SPLIT_WDAY: begin
        cmd.split  = 1'b1;
        cmd.sel    = SPLIT_WDAY;
        state_next = S_ANCHOR;
      end
      S_ANCHOR: begin
        cmd.anchor = 1'b1;
        state_next = S_YEAR;
      end
      S_YEAR: begin
        if (status.year_done) begin
          state_next = S_MONTH;
        end else begin
          cmd.year_step = 1'b1;
        end
      end
      S_MONTH: begin
        if (status.month_done) begin
          if (!out_valid || !out_stall) begin
            cmd.capture = 1'b1;
            state_next  = S_IDLE;
          end
        end else begin
          cmd.month_step = 1'b1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

`ifndef SYNTH
  // a finished result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |-> !(out_valid && out_stall))
    else $error("result captured over a pending transaction");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == S_MUL_SEC))
    else $error("accepted transaction did not start the seconds split");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> (state == S_IDLE) && !out_valid)
    else $error("reset did not return to idle");

  a_one_step: assert property (@(posedge clk) disable iff (rst)
    $countones({cmd.load, cmd.mul, cmd.split, cmd.anchor,
                cmd.year_step, cmd.month_step, cmd.capture}) <= 1)
    else $error("more than one datapath command in a cycle");
`endif

endmodule
`default_nettype wire

/* rtl/unix_time_to_calendar.sv */
// Top level: Unix seconds to UTC calendar date and time.
// From input acceptance to out_valid the controller runs four multiply-and-split pairs
// (seconds, minutes, hours, weekday), the anchor, then the one-year and one-month-per-cycle
// loops, and registers the result; Y (0..87) is the number of years stepped from the 2019,
// 2000 or 1970 anchor and M (0..11) the months stepped. A new transaction is taken only
// while the controller is idle; the next is accepted the cycle after a result registers.
// Reset (rst, synchronous) returns the controller to idle and drops out_valid.
`default_nettype none
module unix_time_to_calendar (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] unix_seconds,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [5:0]       sec_of_minute,
  output logic [5:0]       min_of_hour,
  output logic [4:0]       hour_of_day,
  output logic [2:0]       day_of_week,
  output logic [4:0]       day_of_month,
  output logic [3:0]       month_of_year,
  output logic [11:0]      calendar_year
);
  import ut2cal_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  ut2cal_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  ut2cal_dp u_dp (
    .clk           (clk),
    .cmd           (cmd),
    .status        (status),
    .unix_seconds  (unix_seconds),
    .sec_of_minute (sec_of_minute),
    .min_of_hour   (min_of_hour),
    .hour_of_day   (hour_of_day),
    .day_of_week   (day_of_week),
    .day_of_month  (day_of_month),
    .month_of_year (month_of_year),
    .calendar_year (calendar_year)
  );

endmodule
`default_nettype wire
